// ===== src/slr_pkg.sv =====
package slr_pkg;

   localparam logic [15:0] CH_QUOTE  = 16'h0027;
   localparam logic [15:0] CH_BSLASH = 16'h005C;
   localparam logic [15:0] CH_MASK   = 16'h003F;
   localparam int          MAX_OUT   = 3;

   typedef struct packed {
      logic [15:0] char_in;
      logic        text_last;
   } slr_req_type;

   typedef struct packed {
      logic [15:0] char_out;
      logic        char_valid;
      logic        run_last;
      logic        text_end;
   } slr_rsp_type;

endpackage

// ===== src/sql_literal_redactor.sv =====
// channel | ports                            | transfer when
// --------+----------------------------------+------------------------
// request | req_valid req_ready req_data     | req_valid && req_ready
// result  | rsp_valid rsp_ready rsp_data     | rsp_valid && rsp_ready
//
// One request is decoded in the cycle it transfers and its zero to three
// results go into a three-entry result buffer, one leaving per cycle while
// rsp_ready is high. A request transfers when the buffer is empty or its
// last entry leaves in the same cycle, so single-result text streams at one
// character per cycle while rsp_ready is high; n results leave in turn.
// Synchronous reset clears the scan state and empties the buffer.
module sql_literal_redactor
   import slr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  slr_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output slr_rsp_type rsp_data
);

   logic        in_literal_ff, in_literal_in;
   logic        masked_ff, masked_in;
   logic        escape_ff, escape_in;
   logic        quote_ff, quote_in;

   slr_rsp_type buf_ff [MAX_OUT];
   slr_rsp_type buf_in [MAX_OUT];
   logic [1:0]  cnt_ff, cnt_in;

   logic        req_fire;
   logic        rsp_fire;
   logic        emit_mask, emit_quote, emit_pass;
   logic [1:0]  nchar;
   logic [1:0]  nent;
   logic [1:0]  k;
   logic [15:0] slot [MAX_OUT];
   logic [15:0] c;
   logic        last;

   assign c         = req_data.char_in;
   assign last      = req_data.text_last;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = buf_ff[0];
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign req_fire  = req_valid && req_ready;

   // decode one character against the scan state
   always_comb begin
      emit_mask     = 1'b0;
      emit_quote    = 1'b0;
      emit_pass     = 1'b0;
      in_literal_in = in_literal_ff;
      masked_in     = masked_ff;
      escape_in     = escape_ff;
      quote_in      = quote_ff;
      if (escape_ff) begin
         escape_in = 1'b0;
      end else if (quote_ff) begin
         quote_in = 1'b0;
         if (c == CH_QUOTE) begin
            emit_mask = !masked_ff;
            masked_in = 1'b1;
         end else begin
            emit_mask     = !masked_ff;
            emit_quote    = 1'b1;
            emit_pass     = 1'b1;
            in_literal_in = 1'b0;
            masked_in     = 1'b0;
         end
      end else if (!in_literal_ff) begin
         emit_pass = 1'b1;
         if (c == CH_QUOTE) begin
            in_literal_in = 1'b1;
            masked_in     = 1'b0;
         end
      end else if ((c == CH_BSLASH) && !last) begin
         escape_in = 1'b1;
         emit_mask = !masked_ff;
         masked_in = 1'b1;
      end else if (c == CH_QUOTE) begin
         if (last) begin
            emit_mask     = !masked_ff;
            emit_quote    = 1'b1;
            in_literal_in = 1'b0;
            masked_in     = 1'b0;
         end else begin
            quote_in = 1'b1;
         end
      end else begin
         emit_mask = !masked_ff;
         masked_in = 1'b1;
      end
      if (last) begin
         in_literal_in = 1'b0;
         masked_in     = 1'b0;
         escape_in     = 1'b0;
         quote_in      = 1'b0;
      end
   end

   // pack emitted characters into slots in output order
   always_comb begin
      k = 2'd0;
      for (int i = 0; i < MAX_OUT; i++) begin
         slot[i] = 16'h0000;
      end
      if (emit_mask) begin
         slot[k] = CH_MASK;
         k       = k + 2'd1;
      end
      if (emit_quote) begin
         slot[k] = CH_QUOTE;
         k       = k + 2'd1;
      end
      if (emit_pass) begin
         slot[k] = c;
         k       = k + 2'd1;
      end
      nchar = k;
      nent  = ((nchar == 2'd0) && last) ? 2'd1 : nchar;
   end

   // shift out on a result transfer, load on a request transfer
   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < MAX_OUT; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (rsp_fire) begin
         for (int i = 0; i < MAX_OUT - 1; i++) begin
            buf_in[i] = buf_ff[i + 1];
         end
         cnt_in = cnt_ff - 2'd1;
      end
      if (req_fire) begin
         for (int i = 0; i < MAX_OUT; i++) begin
            buf_in[i].char_out   = slot[i];
            buf_in[i].char_valid = (2'(i) < nchar);
            buf_in[i].run_last   = (2'(i) == nent - 2'd1);
            buf_in[i].text_end   = last && (2'(i) == nent - 2'd1);
         end
         cnt_in = nent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_literal_ff <= 1'b0;
         masked_ff     <= 1'b0;
         escape_ff     <= 1'b0;
         quote_ff      <= 1'b0;
         cnt_ff        <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (req_fire) begin
            in_literal_ff <= in_literal_in;
            masked_ff     <= masked_in;
            escape_ff     <= escape_in;
            quote_ff      <= quote_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_OUT; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

endmodule
